[sv/ack_retransmit_queue_macros.svh]
// Assertion macros used by the ack retransmit queue datapath.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ACK_RETRANSMIT_QUEUE_MACROS_SVH
`define ACK_RETRANSMIT_QUEUE_MACROS_SVH

// Check that b holds in the same cycle as a.
`define ARQ_ASSERT_SAME(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Check that b holds in the cycle after a.
`define ARQ_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

[sv/arq_pkg.sv]
// Package for the ack retransmit queue: sizes, codes and the
// controller/datapath command and status types. Depends on nothing.
package arq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] ACK_TIMEOUT_RESET = 32'd1000;
  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd3;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_ACK     = 2'd1,
    OP_TICK    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_QUEUED    = 3'd0,
    K_FULL      = 3'd1,
    K_ACKED     = 3'd2,
    K_UNMATCHED = 3'd3,
    K_RETRY     = 3'd4,
    K_TICK_DONE = 3'd5
  } kind_t;

  typedef enum logic {
    REG_ACK_TIMEOUT = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_ACK,
    S_TICK,
    S_RETRY,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] packet;
    logic [7:0]  dest;
    logic [31:0] sent;
    logic [7:0]  retries;
  } entry_t;

  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  idx_inc;
    logic  enq_write;
    logic  remove;
    logic  drop_inc;
    logic  retry;
    logic  emit;
    kind_t kind;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic full;
    logic match;
    logic expired;
    logic limit_hit;
  } dp_status_t;

endpackage

[sv/arq_ctrl.sv]
// Controller state machine for the ack retransmit queue.
// Depends on arq_pkg; drives the datapath through arq_pkg::dp_cmd_t.
module arq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          op,
  input  arq_pkg::dp_status_t status,
  output arq_pkg::dp_cmd_t    cmd,
  output logic                busy
);

  arq_pkg::state_t state, state_next;
  arq_pkg::kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arq_pkg::S_IDLE;
      kind  <= arq_pkg::K_QUEUED;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.kind   = kind;
    case (state)
      arq_pkg::S_IDLE: begin
        cmd.load = start;
        if (start) begin
          case (arq_pkg::op_t'(op))
            arq_pkg::OP_ENQUEUE: state_next = arq_pkg::S_ENQ;
            arq_pkg::OP_ACK: begin
              cmd.idx_clr = 1'b1;
              state_next  = arq_pkg::S_ACK;
            end
            arq_pkg::OP_TICK: begin
              cmd.idx_clr = 1'b1;
              state_next  = arq_pkg::S_TICK;
            end
            default: state_next = arq_pkg::S_IDLE;
          endcase
        end
      end
      arq_pkg::S_ENQ: begin
        if (status.full) begin
          kind_next = arq_pkg::K_FULL;
        end else begin
          cmd.enq_write = 1'b1;
          kind_next     = arq_pkg::K_QUEUED;
        end
        state_next = arq_pkg::S_FINAL;
      end
      arq_pkg::S_ACK: begin
        if (status.idx_end) begin
          kind_next  = arq_pkg::K_UNMATCHED;
          state_next = arq_pkg::S_FINAL;
        end else if (status.match) begin
          cmd.remove = 1'b1;
          kind_next  = arq_pkg::K_ACKED;
          state_next = arq_pkg::S_FINAL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      arq_pkg::S_TICK: begin
        if (status.idx_end) begin
          kind_next  = arq_pkg::K_TICK_DONE;
          state_next = arq_pkg::S_FINAL;
        end else if (status.expired) begin
          if (status.limit_hit) begin
            cmd.remove   = 1'b1;
            cmd.drop_inc = 1'b1;
          end else begin
            cmd.retry  = 1'b1;
            state_next = arq_pkg::S_RETRY;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      arq_pkg::S_RETRY: begin
        cmd.emit    = 1'b1;
        cmd.kind    = arq_pkg::K_RETRY;
        cmd.last    = 1'b0;
        cmd.idx_inc = 1'b1;
        state_next  = arq_pkg::S_TICK;
      end
      arq_pkg::S_FINAL: begin
        cmd.emit   = 1'b1;
        cmd.kind   = kind;
        cmd.last   = 1'b1;
        state_next = arq_pkg::S_IDLE;
      end
      default: state_next = arq_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != arq_pkg::S_IDLE);

endmodule

[sv/arq_datapath.sv]
// Datapath for the ack retransmit queue: entry table, scan index, totals,
// configuration registers and the result register. Depends on arq_pkg.
`include "ack_retransmit_queue_macros.svh"

module arq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  arq_pkg::dp_cmd_t     cmd,
  output arq_pkg::dp_status_t  status,
  input  logic [31:0]          seq_num,
  input  logic [15:0]          packet_tag,
  input  logic [7:0]           dest_id,
  input  logic [31:0]          now_ms,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 result_valid,
  output logic [2:0]           kind,
  output logic [31:0]          seq_out,
  output logic [15:0]          packet_out,
  output logic [7:0]           dest_out,
  output logic [3:0]           pending_count,
  output logic [31:0]          retries_total,
  output logic [31:0]          drops_total,
  output logic                 last
);

  arq_pkg::entry_t               table_q [arq_pkg::QUEUE_DEPTH];
  logic [arq_pkg::CNT_W-1:0]     count;
  logic [arq_pkg::CNT_W-1:0]     idx;
  logic [31:0]                   seq_l;
  logic [15:0]                   pkt_l;
  logic [7:0]                    dest_l;
  logic [31:0]                   now_l;
  logic [31:0]                   ack_timeout;
  logic [7:0]                    retry_limit;
  logic [31:0]                   retry_cnt;
  logic [31:0]                   drop_cnt;
  arq_pkg::entry_t               cur;
  logic [31:0]                   elapsed;

  assign cur     = table_q[idx[arq_pkg::IDX_W-1:0]];
  assign elapsed = now_l - cur.sent;

  assign status.idx_end   = (idx >= count);
  assign status.full      = (count >= arq_pkg::CNT_W'(arq_pkg::QUEUE_DEPTH));
  assign status.match     = (cur.seq == seq_l);
  assign status.expired   = (elapsed > ack_timeout);
  assign status.limit_hit = (cur.retries >= retry_limit);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_l  <= seq_num;
      pkt_l  <= packet_tag;
      dest_l <= dest_id;
      now_l  <= now_ms;
    end
    if (cmd.enq_write) begin
      table_q[count[arq_pkg::IDX_W-1:0]] <= '{seq: seq_l, packet: pkt_l, dest: dest_l,
                                              sent: now_l, retries: 8'd0};
    end
    if (cmd.remove) begin
      for (int j = 0; j < arq_pkg::QUEUE_DEPTH - 1; j++) begin
        if (arq_pkg::CNT_W'(j) >= idx) begin
          table_q[j] <= table_q[j + 1];
        end
      end
    end
    if (cmd.retry) begin
      table_q[idx[arq_pkg::IDX_W-1:0]].retries <= cur.retries + 8'd1;
      table_q[idx[arq_pkg::IDX_W-1:0]].sent    <= now_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.enq_write) begin
        count <= count + arq_pkg::CNT_W'(1);
      end else if (cmd.remove) begin
        count <= count - arq_pkg::CNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + arq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_cnt   <= '0;
      drop_cnt    <= '0;
      ack_timeout <= arq_pkg::ACK_TIMEOUT_RESET;
      retry_limit <= arq_pkg::RETRY_LIMIT_RESET;
    end else begin
      if (cmd.retry) begin
        retry_cnt <= retry_cnt + 32'd1;
      end
      if (cmd.drop_inc) begin
        drop_cnt <= drop_cnt + 32'd1;
      end
      if (cfg_write) begin
        case (arq_pkg::cfg_reg_t'(cfg_index))
          arq_pkg::REG_ACK_TIMEOUT: ack_timeout <= cfg_data;
          arq_pkg::REG_RETRY_LIMIT: retry_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind          <= cmd.kind;
      last          <= cmd.last;
      pending_count <= 4'(count);
      retries_total <= retry_cnt;
      drops_total   <= drop_cnt;
      case (cmd.kind)
        arq_pkg::K_RETRY: begin
          seq_out    <= cur.seq;
          packet_out <= cur.packet;
          dest_out   <= cur.dest;
        end
        arq_pkg::K_TICK_DONE: begin
          seq_out    <= '0;
          packet_out <= '0;
          dest_out   <= '0;
        end
        default: begin
          seq_out    <= seq_l;
          packet_out <= '0;
          dest_out   <= '0;
        end
      endcase
    end
  end

  `ARQ_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= arq_pkg::CNT_W'(arq_pkg::QUEUE_DEPTH), "entry count beyond depth")
  `ARQ_ASSERT_SAME(a_retry_not_last, clk, rst, result_valid && kind == arq_pkg::K_RETRY, !last, "retry result marked last")
  `ARQ_ASSERT_NEXT(a_enq_grows, clk, rst, cmd.enq_write, count == $past(count) + arq_pkg::CNT_W'(1), "enqueue did not add an entry")
  `ARQ_ASSERT_SAME(a_enq_not_full, clk, rst, cmd.enq_write, !status.full, "write into a full table")

endmodule

[sv/ack_retransmit_queue.sv]
// Enqueue goes through S_ENQ and S_FINAL, then the registered strobe; acknowledge scans the
// table for a match, tick scans all of it, each retry strobe registered from S_RETRY after its check.
// The scan takes one entry per cycle except where a retry or a drop holds it; start is taken only while idle.
// Synchronous active-high reset empties the table, clears totals and restores the registers.
// The strobe is not held off by the receiver; configuration is always ready.
// Depends on arq_pkg, arq_ctrl and arq_datapath.
module ack_retransmit_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] seq_num,
  input  logic [15:0] packet_tag,
  input  logic [7:0]  dest_id,
  input  logic [31:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [2:0]  kind,
  output logic [31:0] seq_out,
  output logic [15:0] packet_out,
  output logic [7:0]  dest_out,
  output logic [3:0]  pending_count,
  output logic [31:0] retries_total,
  output logic [31:0] drops_total,
  output logic        last
);

  arq_pkg::dp_cmd_t    cmd;
  arq_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  arq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  arq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .seq_num       (seq_num),
    .packet_tag    (packet_tag),
    .dest_id       (dest_id),
    .now_ms        (now_ms),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .kind          (kind),
    .seq_out       (seq_out),
    .packet_out    (packet_out),
    .dest_out      (dest_out),
    .pending_count (pending_count),
    .retries_total (retries_total),
    .drops_total   (drops_total),
    .last          (last)
  );

endmodule
